// File: sv/bss_pkg.sv
// ---------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the brake servo supervisor: fault codes,
// register indexes, register reset values and the input/result beat layout.
// ---------------------------------------------------------------------------
package bss_pkg;

    // fault codes as reported on the result beat
    typedef enum logic [2:0] {
        FAULT_NONE        = 3'd0,
        FAULT_TIMEOUT     = 3'd1,
        FAULT_OSCILLATION = 3'd2,
        FAULT_DEVIATION   = 3'd3,
        FAULT_LATCHED     = 3'd4
    } fault_code_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DEV_THRESHOLD = 3'd0,
        REG_DEV_DEBOUNCE  = 3'd1,
        REG_LATCH_CLEAR   = 3'd2,
        REG_CUTOFF_REPEAT = 3'd3,
        REG_OSC_THRESHOLD = 3'd4,
        REG_OSC_DEBOUNCE  = 3'd5,
        REG_TIMEOUT       = 3'd6
    } cfg_index_t;

    // limits
    localparam logic [6:0]  DUTY_MAX    = 7'd100;
    localparam logic [7:0]  COUNT8_MAX  = 8'hFF;
    localparam logic [15:0] STALE_MAX   = 16'hFFFF;
    // divide by ten for raw < 1024: (raw * 205) >> 11
    localparam logic [17:0] DIV10_MUL   = 18'd205;

    // register reset values
    localparam logic [6:0]  DEV_THRESHOLD_RST = 7'd20;
    localparam logic [7:0]  DEV_DEBOUNCE_RST  = 8'd3;
    localparam logic [7:0]  LATCH_CLEAR_RST   = 8'd50;
    localparam logic [7:0]  CUTOFF_REPEAT_RST = 8'd10;
    localparam logic [6:0]  OSC_THRESHOLD_RST = 7'd30;
    localparam logic [7:0]  OSC_DEBOUNCE_RST  = 8'd3;
    localparam logic [15:0] TIMEOUT_RST       = 16'd9;

    // one input item
    typedef struct packed {
        logic        command_fresh;
        logic [15:0] command_value;
        logic        emergency_stop;
        logic        position_valid;
        logic [9:0]  position_raw;
    } tick_in_t;

    // one result item
    typedef struct packed {
        logic [6:0]  servo_duty;
        logic [6:0]  brake_pos;
        fault_code_t fault_code;
        logic        motor_cutoff;
        logic        pwm_disable;
        logic        cutoff_frame_send;
        logic [1:0]  fault_event;
        logic        all_clear;
    } tick_out_t;

    // configuration register file
    typedef struct packed {
        logic [6:0]  dev_threshold;
        logic [7:0]  dev_debounce;
        logic [7:0]  latch_clear;
        logic [7:0]  cutoff_repeat;
        logic [6:0]  osc_threshold;
        logic [7:0]  osc_debounce;
        logic [15:0] timeout;
    } cfg_regs_t;

    // absolute difference of two percent values
    function automatic logic [6:0] abs_diff7(input logic [6:0] a, input logic [6:0] b);
        logic [6:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

// File: sv/brake_servo_supervisor_core.sv
// ---------------------------------------------------------------------------
// brake_servo_supervisor_core
// One control tick per input beat: clamps the brake command, scales the
// position feedback, debounces timeout, oscillation and deviation faults,
// holds a fault latch and drives the motor cutoff frame sequence.
// ---------------------------------------------------------------------------
// The block takes one tick per clock cycle while the result output is not
// stalled. A tick is captured in an input register, all checks run
// combinationally in comparators and small saturating counters, and the
// result lands in an output register. The
// supervisor state is updated in the same cycle the result is written, so
// the next tick already sees it. s_tready falls only while a result is held,
// m_tready is low and a tick waits in the input register. Configuration
// writes are always taken (cfg_ready is high) and must be made while no tick
// is in flight; index 7 is ignored.
module brake_servo_supervisor_core
(
    input  logic        clk,
    input  logic        rst_n,

    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command_value[15:0], emergency_stop[16],
                                   // position_raw[26:17], zero [31:27]
    input  logic [1:0]  s_tuser,   // command_fresh[0], position_valid[1]

    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // servo_duty[6:0], brake_pos[13:7],
                                   // fault_code[16:14], motor_cutoff[17],
                                   // pwm_disable[18], cutoff_frame_send[19],
                                   // fault_event[21:20], all_clear[22], zero[23]

    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // pipeline registers
    logic                 in_valid_reg;
    bss_pkg::tick_in_t    in_reg;
    logic                 out_valid_reg;
    bss_pkg::tick_out_t   out_reg;
    bss_pkg::cfg_regs_t   cfg_reg;

    // supervisor state
    logic [6:0]            position_reg;
    bss_pkg::fault_code_t  fault_reg;
    logic [15:0]           stale_count_reg;
    logic                  latched_reg;
    logic [7:0]            clear_count_reg;
    logic [7:0]            dev_count_reg;
    logic                  auto_brake_reg;
    logic [7:0]            cutoff_count_reg;
    logic                  cutoff_active_reg;
    logic                  armed_reg;
    logic [6:0]            last_command_reg;
    logic [7:0]            osc_count_reg;

    // next state
    logic [6:0]            position_next;
    bss_pkg::fault_code_t  fault_next;
    logic [15:0]           stale_count_next;
    logic                  latched_next;
    logic [7:0]            clear_count_next;
    logic [7:0]            dev_count_next;
    logic                  auto_brake_next;
    logic [7:0]            cutoff_count_next;
    logic                  cutoff_active_next;
    logic                  armed_next;
    logic [6:0]            last_command_next;
    logic [7:0]            osc_count_next;
    bss_pkg::tick_out_t    out_next;

    logic        advance;
    logic        s_beat;
    logic [17:0] pos_prod;
    logic [6:0]  pos_scaled;

    // handshake
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_beat    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_reg.all_clear, out_reg.fault_event,
                        out_reg.cutoff_frame_send, out_reg.pwm_disable,
                        out_reg.motor_cutoff, out_reg.fault_code,
                        out_reg.brake_pos, out_reg.servo_duty};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_reg.command_fresh  <= s_tuser[0];
            in_reg.command_value  <= s_tdata[15:0];
            in_reg.emergency_stop <= s_tdata[16];
            in_reg.position_valid <= s_tuser[1];
            in_reg.position_raw   <= s_tdata[26:17];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_threshold <= bss_pkg::DEV_THRESHOLD_RST;
            cfg_reg.dev_debounce  <= bss_pkg::DEV_DEBOUNCE_RST;
            cfg_reg.latch_clear   <= bss_pkg::LATCH_CLEAR_RST;
            cfg_reg.cutoff_repeat <= bss_pkg::CUTOFF_REPEAT_RST;
            cfg_reg.osc_threshold <= bss_pkg::OSC_THRESHOLD_RST;
            cfg_reg.osc_debounce  <= bss_pkg::OSC_DEBOUNCE_RST;
            cfg_reg.timeout       <= bss_pkg::TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bss_pkg::cfg_index_t'(cfg_index))
                bss_pkg::REG_DEV_THRESHOLD: cfg_reg.dev_threshold <= cfg_data[6:0];
                bss_pkg::REG_DEV_DEBOUNCE:  cfg_reg.dev_debounce  <= cfg_data[7:0];
                bss_pkg::REG_LATCH_CLEAR:   cfg_reg.latch_clear   <= cfg_data[7:0];
                bss_pkg::REG_CUTOFF_REPEAT: cfg_reg.cutoff_repeat <= cfg_data[7:0];
                bss_pkg::REG_OSC_THRESHOLD: cfg_reg.osc_threshold <= cfg_data[6:0];
                bss_pkg::REG_OSC_DEBOUNCE:  cfg_reg.osc_debounce  <= cfg_data[7:0];
                bss_pkg::REG_TIMEOUT:       cfg_reg.timeout       <= cfg_data;
                default: ;
            endcase
        end
    end

    // position scaling: raw / 10 by reciprocal multiply
    assign pos_prod   = 18'(in_reg.position_raw) * bss_pkg::DIV10_MUL;
    assign pos_scaled = pos_prod[17:11];

    // one tick of supervision
    always_comb
    begin
        logic [6:0]           cmd;
        logic [6:0]           duty;
        bss_pkg::fault_code_t raised_fault;
        logic                 frame;

        position_next      = position_reg;
        fault_next         = fault_reg;
        stale_count_next   = stale_count_reg;
        latched_next       = latched_reg;
        clear_count_next   = clear_count_reg;
        dev_count_next     = dev_count_reg;
        auto_brake_next    = auto_brake_reg;
        cutoff_count_next  = cutoff_count_reg;
        cutoff_active_next = cutoff_active_reg;
        armed_next         = armed_reg;
        osc_count_next     = osc_count_reg;
        raised_fault       = bss_pkg::FAULT_NONE;
        frame              = 1'b0;

        // freshness and stale counter
        if (in_reg.command_fresh)
        begin
            stale_count_next = '0;
            armed_next       = 1'b1;
        end
        else if (stale_count_reg < bss_pkg::STALE_MAX)
        begin
            stale_count_next = stale_count_reg + 16'd1;
        end

        // command clamp
        cmd = (in_reg.command_value > 16'(bss_pkg::DUTY_MAX)) ?
              bss_pkg::DUTY_MAX : in_reg.command_value[6:0];

        // emergency stop
        if (in_reg.emergency_stop)
        begin
            cmd              = bss_pkg::DUTY_MAX;
            auto_brake_next  = 1'b1;
            latched_next     = 1'b1;
            clear_count_next = '0;
        end

        // command timeout
        if (!auto_brake_next && armed_next && stale_count_next >= cfg_reg.timeout)
        begin
            raised_fault     = bss_pkg::FAULT_TIMEOUT;
            auto_brake_next  = 1'b1;
            latched_next     = 1'b1;
            clear_count_next = '0;
        end

        // oscillation check
        if (raised_fault == bss_pkg::FAULT_NONE && !latched_next)
        begin
            if (bss_pkg::abs_diff7(cmd, last_command_reg) > cfg_reg.osc_threshold)
            begin
                if (osc_count_reg < bss_pkg::COUNT8_MAX)
                begin
                    osc_count_next = osc_count_reg + 8'd1;
                end
            end
            else
            begin
                osc_count_next = '0;
            end
            if (osc_count_next >= cfg_reg.osc_debounce)
            begin
                raised_fault = bss_pkg::FAULT_OSCILLATION;
            end
        end
        else
        begin
            osc_count_next = '0;
        end
        last_command_next = cmd;

        if (auto_brake_next)
        begin
            cmd = bss_pkg::DUTY_MAX;
        end
        duty = cmd;

        // position feedback
        if (in_reg.position_valid)
        begin
            position_next = (pos_scaled > bss_pkg::DUTY_MAX) ? bss_pkg::DUTY_MAX : pos_scaled;
        end

        // deviation check
        if (raised_fault == bss_pkg::FAULT_NONE && armed_next)
        begin
            if (bss_pkg::abs_diff7(cmd, position_next) > cfg_reg.dev_threshold)
            begin
                if (dev_count_reg < bss_pkg::COUNT8_MAX)
                begin
                    dev_count_next = dev_count_reg + 8'd1;
                end
                if (dev_count_next >= cfg_reg.dev_debounce)
                begin
                    raised_fault = bss_pkg::FAULT_DEVIATION;
                end
            end
            else
            begin
                dev_count_next = '0;
            end
        end

        // fault latch
        if (raised_fault != bss_pkg::FAULT_NONE)
        begin
            fault_next       = raised_fault;
            latched_next     = 1'b1;
            clear_count_next = '0;
            position_next    = bss_pkg::DUTY_MAX;
            duty             = bss_pkg::DUTY_MAX;
            if (!cutoff_active_reg)
            begin
                cutoff_active_next = 1'b1;
                cutoff_count_next  = '0;
            end
        end
        else if (latched_next)
        begin
            if (clear_count_next < bss_pkg::COUNT8_MAX)
            begin
                clear_count_next = clear_count_next + 8'd1;
            end
            if (clear_count_next >= cfg_reg.latch_clear)
            begin
                latched_next     = 1'b0;
                clear_count_next = '0;
                auto_brake_next  = 1'b0;
                fault_next       = bss_pkg::FAULT_NONE;
                armed_next       = 1'b0;
                stale_count_next = '0;
            end
            else
            begin
                if (fault_next == bss_pkg::FAULT_NONE)
                begin
                    fault_next = bss_pkg::FAULT_LATCHED;
                end
                position_next = bss_pkg::DUTY_MAX;
                duty          = bss_pkg::DUTY_MAX;
            end
        end
        else
        begin
            fault_next = bss_pkg::FAULT_NONE;
        end

        // cutoff frame sequence
        if (cutoff_active_next)
        begin
            if (cutoff_count_next < cfg_reg.cutoff_repeat)
            begin
                frame             = 1'b1;
                cutoff_count_next = cutoff_count_next + 8'd1;
            end
            else
            begin
                cutoff_active_next = 1'b0;
            end
        end

        // result beat
        out_next.servo_duty        = duty;
        out_next.brake_pos         = position_next;
        out_next.fault_code        = fault_next;
        out_next.motor_cutoff      = cutoff_active_next || (fault_next != bss_pkg::FAULT_NONE);
        out_next.pwm_disable       = latched_next;
        out_next.cutoff_frame_send = frame;
        out_next.fault_event       = raised_fault[1:0];
        out_next.all_clear         = (raised_fault == bss_pkg::FAULT_NONE) && !latched_next;
    end

    // state update, one tick per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= '0;
            fault_reg         <= bss_pkg::FAULT_NONE;
            stale_count_reg   <= '0;
            latched_reg       <= 1'b0;
            clear_count_reg   <= '0;
            dev_count_reg     <= '0;
            auto_brake_reg    <= 1'b0;
            cutoff_count_reg  <= '0;
            cutoff_active_reg <= 1'b0;
            armed_reg         <= 1'b0;
            last_command_reg  <= '0;
            osc_count_reg     <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            position_reg      <= position_next;
            fault_reg         <= fault_next;
            stale_count_reg   <= stale_count_next;
            latched_reg       <= latched_next;
            clear_count_reg   <= clear_count_next;
            dev_count_reg     <= dev_count_next;
            auto_brake_reg    <= auto_brake_next;
            cutoff_count_reg  <= cutoff_count_next;
            cutoff_active_reg <= cutoff_active_next;
            armed_reg         <= armed_next;
            last_command_reg  <= last_command_next;
            osc_count_reg     <= osc_count_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            out_reg <= out_next;
        end
    end

    // a set latch always carries a fault code
    assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |-> (fault_reg != bss_pkg::FAULT_NONE))
        else $error("latch set with no fault code");

    // a new fault forces full brake and the latch
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.fault_event != 2'd0) |->
        (out_reg.pwm_disable && out_reg.servo_duty == bss_pkg::DUTY_MAX && !out_reg.all_clear))
        else $error("fault raised without full brake");

    // a cutoff frame is only sent while cutoff is asserted
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.cutoff_frame_send) |-> out_reg.motor_cutoff)
        else $error("cutoff frame without motor cutoff");

endmodule
